FILE: hdl/ffpa_pkg.sv
// Shared types and constants of the first-fit page allocator.
// No dependencies; the interface, sequencer and top files refer to it by scoped names.
package ffpa_pkg;

  localparam int NUM_PAGES = 1024;
  localparam int PAGE_W    = $clog2(NUM_PAGES);
  localparam int COUNT_W   = $clog2(NUM_PAGES + 1);
  localparam int BYTE_W    = 27;
  localparam int NPG_W     = BYTE_W + 1;
  localparam int SHIFT_W   = 5;
  localparam int STAT_W    = 2;

  localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RST = SHIFT_W'(12);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_SPACE = 2'd1,
    STAT_BAD_FREE = 2'd2
  } ffpa_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCAN,
    ST_APPLY,
    ST_RESULT
  } ffpa_state_e;

  typedef struct packed {
    logic shift;
    logic wr_bit;
  } ring_ctrl_t;

endpackage

FILE: hdl/ffpa_intf.sv
// Valid/ready channel interfaces of the page allocator: request, response, config.
// Depends on ffpa_pkg for field widths.
interface ffpa_req_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [ffpa_pkg::BYTE_W-1:0]   byte_count;
  logic [ffpa_pkg::PAGE_W-1:0]   first_page;
  modport source (output valid, output op, output byte_count, output first_page, input ready);
  modport sink   (input valid, input op, input byte_count, input first_page, output ready);
endinterface

interface ffpa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ffpa_pkg::STAT_W-1:0]   status;
  logic [ffpa_pkg::PAGE_W-1:0]   start_page;
  logic [ffpa_pkg::COUNT_W-1:0]  page_count;
  modport source (output valid, output status, output start_page, output page_count,
                  input ready);
  modport sink   (input valid, input status, input start_page, input page_count,
                  output ready);
endinterface

interface ffpa_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ffpa_pkg::SHIFT_W-1:0]  page_shift;
  modport source (output valid, output page_shift, input ready);
  modport sink   (input valid, input page_shift, output ready);
endinterface

FILE: hdl/ffpa_cell.sv
// One cell of the used-page ring: holds one page's used bit.
// Takes its d_i bit on every shift: the neighbour's bit, or the write bit at the tail. No dependencies.
module ffpa_cell (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic shift_i,
  input  logic d_i,
  output logic q_o
);

  logic bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= 1'b0;
    end else if (shift_i) begin
      bit_q <= d_i;
    end
  end

  assign q_o = bit_q;

endmodule

FILE: hdl/ffpa_ctrl.sv
// Sequencer of the page allocator: page rounding, first-fit scan, apply pass,
// result register and config register. Depends on ffpa_pkg and ffpa_intf.
module ffpa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ffpa_cfg_if.sink             cfg_i,
  ffpa_req_if.sink             req_i,
  ffpa_rsp_if.source           rsp_o,
  input  logic                 head_bit_i,
  output ffpa_pkg::ring_ctrl_t ring_o
);

  ffpa_pkg::ffpa_state_e              state_q, state_d;
  logic [ffpa_pkg::SHIFT_W-1:0]       page_shift_q;
  logic                               op_q;
  logic [ffpa_pkg::PAGE_W-1:0]        first_q;
  logic [ffpa_pkg::NPG_W-1:0]         npg_q;
  logic [ffpa_pkg::PAGE_W-1:0]        cnt_q, cnt_d;
  logic [ffpa_pkg::COUNT_W-1:0]       run_q, run_d;
  logic [ffpa_pkg::COUNT_W-1:0]       count_q, count_d;
  logic                               found_q, found_d;
  logic                               bad_q, bad_d;
  logic [ffpa_pkg::PAGE_W-1:0]        lo_q, lo_d;
  logic [ffpa_pkg::COUNT_W-1:0]       hi_q, hi_d;
  ffpa_pkg::ffpa_status_e             res_status_q, res_status_d;
  logic [ffpa_pkg::PAGE_W-1:0]        res_start_q, res_start_d;
  logic [ffpa_pkg::COUNT_W-1:0]       res_count_q, res_count_d;
  logic                               out_valid_q, out_valid_d;
  ffpa_pkg::ffpa_status_e             out_status_q;
  logic [ffpa_pkg::PAGE_W-1:0]        out_start_q;
  logic [ffpa_pkg::COUNT_W-1:0]       out_count_q;
  logic                               load_out;
  logic                               req_xfer;
  logic                               last;
  logic                               in_range;
  logic [ffpa_pkg::BYTE_W-1:0]        size;
  logic [ffpa_pkg::BYTE_W-1:0]        mask;
  logic [ffpa_pkg::NPG_W-1:0]         npg;
  logic [ffpa_pkg::NPG_W:0]           free_end;

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = (state_q == ffpa_pkg::ST_IDLE);
  assign req_xfer    = req_i.valid && req_i.ready;

  assign size = (req_i.byte_count == '0) ? ffpa_pkg::BYTE_W'(1) : req_i.byte_count;
  assign mask = (ffpa_pkg::BYTE_W'(1) << page_shift_q) - ffpa_pkg::BYTE_W'(1);
  assign npg  = ffpa_pkg::NPG_W'(size >> page_shift_q)
              + ffpa_pkg::NPG_W'(|(size & mask));

  assign free_end = (ffpa_pkg::NPG_W + 1)'(first_q) + (ffpa_pkg::NPG_W + 1)'(npg_q);
  assign last     = (cnt_q == ffpa_pkg::PAGE_W'(ffpa_pkg::NUM_PAGES - 1));
  assign in_range = (cnt_q >= lo_q) && ({1'b0, cnt_q} < hi_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_shift_q <= ffpa_pkg::PAGE_SHIFT_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      page_shift_q <= cfg_i.page_shift;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      op_q    <= req_i.op;
      first_q <= req_i.first_page;
      npg_q   <= npg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ffpa_pkg::ST_IDLE;
      cnt_q       <= '0;
      run_q       <= '0;
      count_q     <= '0;
      found_q     <= 1'b0;
      bad_q       <= 1'b0;
      lo_q        <= '0;
      hi_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      run_q       <= run_d;
      count_q     <= count_d;
      found_q     <= found_d;
      bad_q       <= bad_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_start_q  <= res_start_d;
    res_count_q  <= res_count_d;
    if (load_out) begin
      out_status_q <= res_status_q;
      out_start_q  <= res_start_q;
      out_count_q  <= res_count_q;
    end
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    run_d        = run_q;
    count_d      = count_q;
    found_d      = found_q;
    bad_d        = bad_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    res_status_d = res_status_q;
    res_start_d  = res_start_q;
    res_count_d  = res_count_q;
    load_out     = 1'b0;
    ring_o.shift  = 1'b0;
    ring_o.wr_bit = head_bit_i;
    case (state_q)
      ffpa_pkg::ST_IDLE: begin
        if (req_xfer) begin
          state_d = ffpa_pkg::ST_PREP;
        end
      end
      ffpa_pkg::ST_PREP: begin
        cnt_d   = '0;
        run_d   = '0;
        found_d = 1'b0;
        bad_d   = 1'b0;
        count_d = npg_q[ffpa_pkg::COUNT_W-1:0];
        if (op_q == ffpa_pkg::OP_ALLOC) begin
          if (npg_q > ffpa_pkg::NPG_W'(ffpa_pkg::NUM_PAGES)) begin
            res_status_d = ffpa_pkg::STAT_NO_SPACE;
            res_start_d  = '0;
            res_count_d  = '0;
            state_d      = ffpa_pkg::ST_RESULT;
          end else begin
            state_d = ffpa_pkg::ST_SCAN;
          end
        end else begin
          if (free_end > (ffpa_pkg::NPG_W + 1)'(ffpa_pkg::NUM_PAGES)) begin
            res_status_d = ffpa_pkg::STAT_BAD_FREE;
            res_start_d  = '0;
            res_count_d  = '0;
            state_d      = ffpa_pkg::ST_RESULT;
          end else begin
            lo_d    = first_q;
            hi_d    = free_end[ffpa_pkg::COUNT_W-1:0];
            state_d = ffpa_pkg::ST_SCAN;
          end
        end
      end
      ffpa_pkg::ST_SCAN: begin
        ring_o.shift = 1'b1;
        cnt_d        = cnt_q + ffpa_pkg::PAGE_W'(1);
        if (op_q == ffpa_pkg::OP_ALLOC) begin
          if (!found_q) begin
            if (head_bit_i) begin
              run_d = '0;
            end else begin
              if (run_q == '0) begin
                lo_d = cnt_q;
              end
              run_d = run_q + ffpa_pkg::COUNT_W'(1);
              if (run_d == count_q) begin
                found_d = 1'b1;
                hi_d    = {1'b0, cnt_q} + ffpa_pkg::COUNT_W'(1);
              end
            end
          end
        end else if (in_range && !head_bit_i) begin
          bad_d = 1'b1;
        end
        if (last) begin
          if (op_q == ffpa_pkg::OP_ALLOC && !found_d) begin
            res_status_d = ffpa_pkg::STAT_NO_SPACE;
            res_start_d  = '0;
            res_count_d  = '0;
            state_d      = ffpa_pkg::ST_RESULT;
          end else if (op_q == ffpa_pkg::OP_FREE && bad_d) begin
            res_status_d = ffpa_pkg::STAT_BAD_FREE;
            res_start_d  = '0;
            res_count_d  = '0;
            state_d      = ffpa_pkg::ST_RESULT;
          end else begin
            state_d = ffpa_pkg::ST_APPLY;
          end
        end
      end
      ffpa_pkg::ST_APPLY: begin
        ring_o.shift = 1'b1;
        cnt_d        = cnt_q + ffpa_pkg::PAGE_W'(1);
        if (in_range) begin
          ring_o.wr_bit = (op_q == ffpa_pkg::OP_ALLOC);
        end
        if (last) begin
          res_status_d = ffpa_pkg::STAT_OK;
          res_start_d  = lo_q;
          res_count_d  = count_q;
          state_d      = ffpa_pkg::ST_RESULT;
        end
      end
      ffpa_pkg::ST_RESULT: begin
        if (!out_valid_q || rsp_o.ready) begin
          load_out = 1'b1;
          state_d  = ffpa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ffpa_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = ffpa_pkg::STAT_W'(out_status_q);
  assign rsp_o.start_page = out_start_q;
  assign rsp_o.page_count = out_count_q;

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q != ffpa_pkg::STAT_OK) |->
      (out_start_q == '0 && out_count_q == '0))
    else $error("error result carries a nonzero run");

  a_run_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ffpa_pkg::ST_APPLY && op_q == ffpa_pkg::OP_ALLOC) |->
      (hi_q == {1'b0, lo_q} + count_q))
    else $error("granted run span does not match page count");

  a_scan_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ffpa_pkg::ST_SCAN && $past(state_q) == ffpa_pkg::ST_PREP) |->
      (cnt_q == '0))
    else $error("scan began away from page zero");

  a_ring_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ffpa_pkg::ST_IDLE) |-> (cnt_q == '0 && !ring_o.shift))
    else $error("page ring out of alignment while idle");

endmodule

FILE: hdl/first_fit_page_allocator.sv
// First-fit contiguous page allocator over NUM_PAGES pages, one used bit per page.
// An oversize or out-of-region request goes to the result without a scan, and a failed
// scan goes to it without the write pass; the ring of page cells rotates one page past
// the scan head per cycle, once to search and once to write. One request at a time:
// a new request is taken only once the result is in the output register and the
// sequencer is idle again. Reset frees every page, sets page_shift 12.
module first_fit_page_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  ffpa_cfg_if.sink    cfg_i,
  ffpa_req_if.sink    req_i,
  ffpa_rsp_if.source  rsp_o
);

  ffpa_pkg::ring_ctrl_t              ring;
  logic [ffpa_pkg::NUM_PAGES-1:0]    used;

  ffpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_i),
    .req_i      (req_i),
    .rsp_o      (rsp_o),
    .head_bit_i (used[0]),
    .ring_o     (ring)
  );

  for (genvar k = 0; k < ffpa_pkg::NUM_PAGES; k++) begin : g_cell
    logic d;
    if (k == ffpa_pkg::NUM_PAGES - 1) begin : g_tail
      assign d = ring.wr_bit;
    end else begin : g_mid
      assign d = used[k+1];
    end
    ffpa_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (ring.shift),
      .d_i     (d),
      .q_o     (used[k])
    );
  end

endmodule
